@@ rtl/usbsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB standard request handler package
// Shared types, request codes and result codes for the request handler.
// ----------------------------------------------------------------------------
package usbsr_pkg;

    // Result actions.
    typedef enum logic [2:0] {
        ACT_REPLY     = 3'd0,
        ACT_HANDSHAKE = 3'd1,
        ACT_STALL     = 3'd2,
        ACT_FORWARD   = 3'd3,
        ACT_DESCR     = 3'd4,
        ACT_STRING    = 3'd5
    } action_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SELF_PWR     = 3'd0,
        REG_HIGH_SPEED   = 3'd1,
        REG_DEV_DESCR    = 3'd2,
        REG_QUAL_DESCR   = 3'd3,
        REG_HS_CONFIG    = 3'd4,
        REG_FS_CONFIG    = 3'd5
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE    = 8'h03;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;

    // Request types.
    localparam logic [7:0] RT_DEVICE_OUT = 8'h00;
    localparam logic [7:0] RT_EP_OUT     = 8'h02;
    localparam logic [7:0] RT_DEVICE_IN  = 8'h80;
    localparam logic [7:0] RT_IFACE_IN   = 8'h81;
    localparam logic [7:0] RT_EP_IN      = 8'h82;

    // Feature selectors.
    localparam logic [7:0] FEAT_EP_HALT       = 8'h00;
    localparam logic [7:0] FEAT_REMOTE_WAKEUP = 8'h01;
    localparam logic [7:0] FEAT_TEST_MODE     = 8'h02;

    // Descriptor types.
    localparam logic [7:0] DT_DEVICE       = 8'h01;
    localparam logic [7:0] DT_CONFIG       = 8'h02;
    localparam logic [7:0] DT_STRING       = 8'h03;
    localparam logic [7:0] DT_QUALIFIER    = 8'h06;
    localparam logic [7:0] DT_OTHER_SPEED  = 8'h07;

    // Endpoint slot numbers.
    localparam int SLOT_W = 3;

    typedef struct packed {
        logic [7:0] request_type;
        logic [7:0] request_code;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic [7:0] index_low;
    } usbsr_req_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  reply_byte;
        logic [1:0]  reply_length;
        logic [15:0] descriptor_address;
        logic [7:0]  string_index;
        logic        toggle_reset;
        logic [7:0]  toggle_endpoint;
    } usbsr_result_t;

    typedef struct packed {
        logic        self_pwr;
        logic        high_speed;
        logic [15:0] device_descriptor_address;
        logic [15:0] qualifier_descriptor_address;
        logic [15:0] highspeed_config_address;
        logic [15:0] fullspeed_config_address;
    } usbsr_cfg_t;

endpackage

@@ rtl/usbsr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB standard request handler channels
// Valid/ready channels for setup requests and for result actions.
// ----------------------------------------------------------------------------
interface usbsr_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] request_type;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] index_low;

    modport source (
        output valid, request_type, request_code, value_low, value_high, index_low,
        input  ready
    );
    modport sink (
        input  valid, request_type, request_code, value_low, value_high, index_low,
        output ready
    );
endinterface

interface usbsr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  reply_byte;
    logic [1:0]  reply_length;
    logic [15:0] descriptor_address;
    logic [7:0]  string_index;
    logic        toggle_reset;
    logic [7:0]  toggle_endpoint;

    modport source (
        output valid, action, reply_byte, reply_length, descriptor_address,
               string_index, toggle_reset, toggle_endpoint,
        input  ready
    );
    modport sink (
        input  valid, action, reply_byte, reply_length, descriptor_address,
               string_index, toggle_reset, toggle_endpoint,
        output ready
    );
endinterface

@@ rtl/usb_standard_request_handler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB standard request handler core
// Answers decoded setup packets with one action each, keeping the
// remote-wakeup flag and endpoint stall bits.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  req       in         one decoded setup packet per transfer
//  rsp       out        one action per transfer
//  cfg_*     in         register writes, one per cycle with cfg_wr_en
//
// A request is held in the input register and then moves to the result
// register, from which its action is offered.
// One request is taken every cycle while the result side keeps up.
// Reset clears the valid flags, the wakeup flag and all stall bits.
// When rsp stalls, the input register fills and req.ready drops.
// ----------------------------------------------------------------------------
module usb_standard_request_handler_core #(
    parameter int ENDPOINT_SLOTS = 7
) (
    input  logic                              clk,
    input  logic                              rst_n,
    usbsr_req_if.sink                         req,
    usbsr_rsp_if.source                       rsp,
    input  logic                              cfg_wr_en,
    input  logic [usbsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [usbsr_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import usbsr_pkg::*;

    usbsr_cfg_t    cfg;
    usbsr_req_t    req_reg;
    logic          req_valid_reg;
    usbsr_result_t result;
    usbsr_result_t rsp_reg;
    logic          rsp_valid_reg;
    logic          rsp_free;
    logic          advance;

    usbsr_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    usbsr_engine #(
        .ENDPOINT_SLOTS (ENDPOINT_SLOTS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .req    (req_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Pipeline flow control.
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign advance   = req_valid_reg && rsp_free;
    assign req.ready = !req_valid_reg || rsp_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            req_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            req_reg.request_type <= req.request_type;
            req_reg.request_code <= req.request_code;
            req_reg.value_low    <= req.value_low;
            req_reg.value_high   <= req.value_high;
            req_reg.index_low    <= req.index_low;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_free)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp.valid              = rsp_valid_reg;
    assign rsp.action             = rsp_reg.action;
    assign rsp.reply_byte         = rsp_reg.reply_byte;
    assign rsp.reply_length       = rsp_reg.reply_length;
    assign rsp.descriptor_address = rsp_reg.descriptor_address;
    assign rsp.string_index       = rsp_reg.string_index;
    assign rsp.toggle_reset       = rsp_reg.toggle_reset;
    assign rsp.toggle_endpoint    = rsp_reg.toggle_endpoint;

    // A full pipeline with a stalled output takes no new request.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && rsp_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken while pipeline full");

    // Reply length is only given with reply data.
    a_len_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.action != ACT_REPLY) |-> rsp_reg.reply_length == 2'd0)
        else $error("reply length without reply action");

    // A toggle reset comes only with a handshake.
    a_toggle_hs: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.toggle_reset) |-> rsp_reg.action == ACT_HANDSHAKE)
        else $error("toggle reset without handshake");

    // A request in the input register moves on when the result side is free.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && !rsp_valid_reg) |=> rsp_valid_reg)
        else $error("request did not advance");

endmodule

@@ rtl/usbsr_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB standard request handler configuration registers
// Write-only register file for power, speed and descriptor addresses.
// ----------------------------------------------------------------------------
module usbsr_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [usbsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [usbsr_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    output usbsr_pkg::usbsr_cfg_t                 cfg
);
    import usbsr_pkg::*;

    usbsr_cfg_t cfg_reg;
    usbsr_cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SELF_PWR:     cfg_next.self_pwr     = cfg_wr_data[0];
                REG_HIGH_SPEED:   cfg_next.high_speed   = cfg_wr_data[0];
                REG_DEV_DESCR:    cfg_next.device_descriptor_address    = cfg_wr_data;
                REG_QUAL_DESCR:   cfg_next.qualifier_descriptor_address = cfg_wr_data;
                REG_HS_CONFIG:    cfg_next.highspeed_config_address     = cfg_wr_data;
                REG_FS_CONFIG:    cfg_next.fullspeed_config_address     = cfg_wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/usbsr_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// USB standard request handler decode engine
// Decodes one registered setup request into an action and keeps the
// remote-wakeup flag and the endpoint stall bits.
// ----------------------------------------------------------------------------
module usbsr_engine #(
    parameter int ENDPOINT_SLOTS = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  usbsr_pkg::usbsr_req_t    req,
    input  usbsr_pkg::usbsr_cfg_t    cfg,
    output usbsr_pkg::usbsr_result_t result
);
    import usbsr_pkg::*;

    logic                      remote_wakeup_reg;
    logic                      remote_wakeup_next;
    logic [ENDPOINT_SLOTS-1:0] stall_reg;
    logic [ENDPOINT_SLOTS-1:0] stall_next;

    logic [SLOT_W-1:0]         slot;
    logic                      slot_known;
    logic                      ep_ok;
    logic [ENDPOINT_SLOTS-1:0] slot_sel;
    logic                      ep_stalled;
    logic [15:0]               cfg_addr_cur;
    logic [15:0]               cfg_addr_other;

    // Map the endpoint byte onto its stall slot.
    always_comb
    begin
        slot       = '0;
        slot_known = 1'b1;
        case (req.index_low[6:0])
            7'd0:    slot = 3'd0;
            7'd1:    slot = req.index_low[7] ? 3'd2 : 3'd1;
            7'd2:    slot = 3'd3;
            7'd4:    slot = 3'd4;
            7'd6:    slot = 3'd5;
            7'd8:    slot = 3'd6;
            default: slot_known = 1'b0;
        endcase
    end

    // One-hot slot select; slots beyond the configured count are invalid.
    always_comb
    begin
        for (int i = 0; i < ENDPOINT_SLOTS; i++)
        begin
            slot_sel[i] = slot_known && (int'(slot) == i);
        end
    end

    assign ep_ok      = |slot_sel;
    assign ep_stalled = |(stall_reg & slot_sel);

    // Speed decides which configuration descriptor is current.
    assign cfg_addr_cur   = cfg.high_speed ? cfg.highspeed_config_address
                                           : cfg.fullspeed_config_address;
    assign cfg_addr_other = cfg.high_speed ? cfg.fullspeed_config_address
                                           : cfg.highspeed_config_address;

    // Request decode and state update.
    always_comb
    begin
        result             = '0;
        result.action      = ACT_STALL;
        remote_wakeup_next = remote_wakeup_reg;
        stall_next         = stall_reg;
        case (req.request_code)
            REQ_GET_STATUS:
            begin
                if (req.request_type == RT_DEVICE_IN)
                begin
                    result.action       = ACT_REPLY;
                    result.reply_byte   = {6'd0, remote_wakeup_reg, cfg.self_pwr};
                    result.reply_length = 2'd2;
                end
                else if (req.request_type == RT_IFACE_IN)
                begin
                    result.action       = ACT_REPLY;
                    result.reply_length = 2'd2;
                end
                else if (req.request_type == RT_EP_IN && ep_ok)
                begin
                    result.action       = ACT_REPLY;
                    result.reply_byte   = {7'd0, ep_stalled};
                    result.reply_length = 2'd2;
                end
            end
            REQ_CLEAR_FEATURE:
            begin
                if (req.request_type == RT_DEVICE_OUT)
                begin
                    if (req.value_low == FEAT_REMOTE_WAKEUP)
                    begin
                        remote_wakeup_next = 1'b0;
                        result.action      = ACT_HANDSHAKE;
                    end
                end
                else if (req.request_type == RT_EP_OUT)
                begin
                    if (req.value_low == FEAT_EP_HALT && ep_ok)
                    begin
                        stall_next    = stall_reg & ~slot_sel;
                        result.action = ACT_HANDSHAKE;
                    end
                end
                else
                begin
                    result.action = ACT_FORWARD;
                end
            end
            REQ_SET_FEATURE:
            begin
                if (req.request_type == RT_DEVICE_OUT)
                begin
                    if (req.value_low == FEAT_TEST_MODE)
                    begin
                        result.action = ACT_HANDSHAKE;
                    end
                    else if (req.value_low == FEAT_REMOTE_WAKEUP)
                    begin
                        remote_wakeup_next = 1'b1;
                        result.action      = ACT_HANDSHAKE;
                    end
                end
                else if (req.request_type == RT_EP_OUT)
                begin
                    if (req.value_low == FEAT_EP_HALT && ep_ok)
                    begin
                        stall_next             = stall_reg | slot_sel;
                        result.action          = ACT_HANDSHAKE;
                        result.toggle_reset    = 1'b1;
                        result.toggle_endpoint = req.index_low;
                    end
                end
                else
                begin
                    result.action = ACT_FORWARD;
                end
            end
            REQ_GET_DESCRIPTOR:
            begin
                case (req.value_high)
                    DT_DEVICE:
                    begin
                        result.action             = ACT_DESCR;
                        result.descriptor_address = cfg.device_descriptor_address;
                    end
                    DT_CONFIG:
                    begin
                        result.action             = ACT_DESCR;
                        result.descriptor_address = cfg_addr_cur;
                    end
                    DT_STRING:
                    begin
                        result.action       = ACT_STRING;
                        result.string_index = req.value_low;
                    end
                    DT_QUALIFIER:
                    begin
                        result.action             = ACT_DESCR;
                        result.descriptor_address = cfg.qualifier_descriptor_address;
                    end
                    DT_OTHER_SPEED:
                    begin
                        result.action             = ACT_DESCR;
                        result.descriptor_address = cfg_addr_other;
                    end
                    default:
                    begin
                        result.action = ACT_STALL;
                    end
                endcase
            end
            default:
            begin
                result.action = ACT_FORWARD;
            end
        endcase
    end

    // State changes only when the request moves on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_wakeup_reg <= 1'b0;
            stall_reg         <= '0;
        end
        else if (take)
        begin
            remote_wakeup_reg <= remote_wakeup_next;
            stall_reg         <= stall_next;
        end
    end

    // The stall bits never change without a request being taken.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(stall_reg))
        else $error("stall bits changed without a request");

    // The wakeup flag never changes without a request being taken.
    a_wakeup_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(remote_wakeup_reg))
        else $error("remote wakeup changed without a request");

endmodule
